>>> sv/dfv_pkg.sv
// shared types and constants of the depth frame variance block
package dfv_pkg;

    // fixed field widths and the default zone count
    localparam int DIST_W        = 13;
    localparam int VAR_W         = 26;
    localparam int COUNT_W       = 7;
    localparam int MAX_ZONES_DEF = 64;

    // controller states
    typedef enum logic [2:0] {
        S_LOAD,
        S_MEAN_GO,
        S_MEAN_WAIT,
        S_PASS_GO,
        S_PASS_WAIT,
        S_VAR_GO,
        S_VAR_WAIT,
        S_DONE
    } t_state;

    // commands from controller to datapath
    typedef struct packed {
        logic load_en;
        logic clear_frame;
        logic mean_start;
        logic mean_latch;
        logic pass_start;
        logic var_start;
        logic out_load;
    } t_dp_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic div_done;
        logic pass_done;
        logic out_free;
    } t_dp_stat;

endpackage

>>> sv/dfv_ram.sv
// generic single write port ram with registered read
module dfv_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // write and registered read
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> sv/dfv_div.sv
// restoring divider, one quotient bit per cycle
module dfv_div #(
    parameter int N_W = 33,
    parameter int D_W = 7
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic [N_W-1:0] i_dividend,
    input  logic [D_W-1:0] i_divisor,
    output logic           o_done,
    output logic [N_W-1:0] o_quotient
);

    localparam int STEP_W = $clog2(N_W + 1);

    logic [STEP_W-1:0] r_step, n_step;
    logic              r_done, n_done;
    logic [D_W-1:0]    r_rem, n_rem;
    logic [N_W-1:0]    r_quo, n_quo;
    logic [D_W-1:0]    r_div, n_div;
    logic [D_W:0]      w_trial;
    logic              w_fit;

    // one step of shift and trial subtract
    always_comb begin
        w_trial = {r_rem, r_quo[N_W-1]};
        w_fit   = (w_trial >= {1'b0, r_div});
        n_step  = r_step;
        n_done  = 1'b0;
        n_rem   = r_rem;
        n_quo   = r_quo;
        n_div   = r_div;
        if (i_start) begin
            n_step = STEP_W'(N_W);
            n_rem  = '0;
            n_quo  = i_dividend;
            n_div  = i_divisor;
        end else if (r_step != '0) begin
            n_step = r_step - 1'b1;
            n_done = (r_step == STEP_W'(1));
            n_rem  = w_fit ? D_W'(w_trial - {1'b0, r_div}) : w_trial[D_W-1:0];
            n_quo  = {r_quo[N_W-2:0], w_fit};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= '0;
            r_done <= 1'b0;
        end else begin
            r_step <= n_step;
            r_done <= n_done;
        end
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_div <= n_div;
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

>>> sv/dfv_ctrl.sv
// frame sequencing state machine
module dfv_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               i_last_zone,
    input  dfv_pkg::t_dp_stat  i_stat,
    output logic               o_stall,
    output dfv_pkg::t_dp_cmd   o_cmd
);

    dfv_pkg::t_state r_state, n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dfv_pkg::S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_stall = 1'b1;
        unique case (r_state)
            dfv_pkg::S_LOAD: begin
                o_stall       = 1'b0;
                o_cmd.load_en = i_valid;
                if (i_valid && i_last_zone) begin
                    n_state = dfv_pkg::S_MEAN_GO;
                end
            end
            dfv_pkg::S_MEAN_GO: begin
                o_cmd.mean_start = 1'b1;
                n_state          = dfv_pkg::S_MEAN_WAIT;
            end
            dfv_pkg::S_MEAN_WAIT: begin
                if (i_stat.div_done) begin
                    o_cmd.mean_latch = 1'b1;
                    n_state          = dfv_pkg::S_PASS_GO;
                end
            end
            dfv_pkg::S_PASS_GO: begin
                o_cmd.pass_start = 1'b1;
                n_state          = dfv_pkg::S_PASS_WAIT;
            end
            dfv_pkg::S_PASS_WAIT: begin
                if (i_stat.pass_done) begin
                    n_state = dfv_pkg::S_VAR_GO;
                end
            end
            dfv_pkg::S_VAR_GO: begin
                o_cmd.var_start = 1'b1;
                n_state         = dfv_pkg::S_VAR_WAIT;
            end
            dfv_pkg::S_VAR_WAIT: begin
                if (i_stat.div_done) begin
                    n_state = dfv_pkg::S_DONE;
                end
            end
            dfv_pkg::S_DONE: begin
                // wait for the output register to free up
                if (i_stat.out_free) begin
                    o_cmd.out_load    = 1'b1;
                    o_cmd.clear_frame = 1'b1;
                    n_state           = dfv_pkg::S_LOAD;
                end
            end
            default: begin
                n_state = dfv_pkg::S_LOAD;
            end
        endcase
    end

endmodule

>>> sv/dfv_dpath.sv
// frame store, accumulators, second pass pipeline, divider and output register
module dfv_dpath #(
    parameter int MAX_ZONES = dfv_pkg::MAX_ZONES_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  dfv_pkg::t_dp_cmd            i_cmd,
    input  logic [dfv_pkg::DIST_W-1:0]  i_distance,
    output dfv_pkg::t_dp_stat           o_stat,
    input  logic                        i_out_stall,
    output logic                        o_out_valid,
    output logic [dfv_pkg::VAR_W-1:0]   o_variance,
    output logic [dfv_pkg::DIST_W-1:0]  o_mean,
    output logic [dfv_pkg::COUNT_W-1:0] o_valid_count,
    output logic                        o_no_valid
);

    localparam int DW     = dfv_pkg::DIST_W;
    localparam int CNT_W  = $clog2(MAX_ZONES + 1);
    localparam int ADDR_W = $clog2(MAX_ZONES);
    localparam int SUM_W  = DW + CNT_W;
    localparam int SQ_W   = 2 * DW + CNT_W;
    localparam int CW     = dfv_pkg::COUNT_W;

    // frame accumulation
    logic [CNT_W-1:0] r_zone_idx;
    logic [CNT_W-1:0] r_tally;
    logic [SUM_W-1:0] r_sum;
    logic             w_room;
    logic             w_wr_en;

    assign w_room  = (r_zone_idx != CNT_W'(MAX_ZONES));
    assign w_wr_en = i_cmd.load_en && w_room;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear_frame) begin
            r_zone_idx <= '0;
            r_tally    <= '0;
            r_sum      <= '0;
        end else if (w_wr_en) begin
            r_zone_idx <= r_zone_idx + 1'b1;
            if (i_distance != '0) begin
                r_tally <= r_tally + 1'b1;
                r_sum   <= r_sum + SUM_W'(i_distance);
            end
        end
    end

    // second pass read side
    logic              r_pass_run;
    logic [CNT_W-1:0]  r_pass_idx;
    logic              w_issue;
    logic [DW-1:0]     w_rd_data;

    assign w_issue = r_pass_run && (r_pass_idx != r_zone_idx);

    dfv_ram #(
        .WIDTH (DW),
        .DEPTH (MAX_ZONES)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (r_zone_idx[ADDR_W-1:0]),
        .i_wr_data (i_distance),
        .i_rd_en   (w_issue),
        .i_rd_addr (r_pass_idx[ADDR_W-1:0]),
        .o_rd_data (w_rd_data)
    );

    // shared divider for mean and variance
    logic            w_div_done;
    logic [SQ_W-1:0] w_quo;
    logic [SQ_W-1:0] r_sq_acc;
    logic [SQ_W-1:0] w_dividend;

    assign w_dividend = i_cmd.var_start ? r_sq_acc : {{(SQ_W - SUM_W){1'b0}}, r_sum};

    dfv_div #(
        .N_W (SQ_W),
        .D_W (CNT_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.mean_start || i_cmd.var_start),
        .i_dividend (w_dividend),
        .i_divisor  (r_tally),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

    logic [DW-1:0] r_mean;

    always_ff @(posedge i_clk) begin
        if (i_cmd.mean_latch) begin
            r_mean <= w_quo[DW-1:0];
        end
    end

    // pass pipeline: read, distance from mean, square, accumulate
    logic                r_s1, r_s2, r_s3;
    logic [DW-1:0]       r_diff;
    logic [2*DW-1:0]     r_sq;
    logic [DW-1:0]       w_diff;

    always_comb begin
        if (w_rd_data == '0) begin
            w_diff = '0;
        end else if (w_rd_data >= r_mean) begin
            w_diff = w_rd_data - r_mean;
        end else begin
            w_diff = r_mean - w_rd_data;
        end
    end

    logic w_pass_done;

    assign w_pass_done = r_pass_run && !w_issue && !r_s1 && !r_s2 && !r_s3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pass_run <= 1'b0;
            r_s1       <= 1'b0;
            r_s2       <= 1'b0;
            r_s3       <= 1'b0;
        end else begin
            if (i_cmd.pass_start) begin
                r_pass_run <= 1'b1;
            end else if (w_pass_done) begin
                r_pass_run <= 1'b0;
            end
            r_s1 <= w_issue;
            r_s2 <= r_s1;
            r_s3 <= r_s2;
        end
        if (i_cmd.pass_start) begin
            r_pass_idx <= '0;
        end else if (w_issue) begin
            r_pass_idx <= r_pass_idx + 1'b1;
        end
        r_diff <= w_diff;
        r_sq   <= r_diff * r_diff;
        if (i_cmd.pass_start) begin
            r_sq_acc <= '0;
        end else if (r_s3) begin
            r_sq_acc <= r_sq_acc + SQ_W'(r_sq);
        end
    end

    // output register
    logic                r_out_valid;
    logic [dfv_pkg::VAR_W-1:0] r_variance;
    logic [DW-1:0]       r_out_mean;
    logic [CW-1:0]       r_count;
    logic                r_no_valid;
    logic                w_none;
    logic [CNT_W+CW-1:0] w_count_ext;

    assign w_none      = (r_tally == '0);
    assign w_count_ext = {{CW{1'b0}}, r_tally};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
        if (i_cmd.out_load) begin
            r_variance <= w_none ? '0 : w_quo[dfv_pkg::VAR_W-1:0];
            r_out_mean <= w_none ? '0 : r_mean;
            r_count    <= w_count_ext[CW-1:0];
            r_no_valid <= w_none;
        end
    end

    assign o_stat.div_done  = w_div_done;
    assign o_stat.pass_done = w_pass_done;
    assign o_stat.out_free  = !r_out_valid || !i_out_stall;

    assign o_out_valid   = r_out_valid;
    assign o_variance    = r_variance;
    assign o_mean        = r_out_mean;
    assign o_valid_count = r_count;
    assign o_no_valid    = r_no_valid;

endmodule

>>> sv/depth_frame_variance_top.sv
// top level of the depth frame variance block
//
// Input channel (i_valid / o_stall): one zone distance per transfer, with
// i_last_zone set on the final zone of a frame. Zeros are invalid readings.
// Zones are taken one per cycle while a frame loads; zones beyond
// MAX_ZONES are dropped, though their last flag still closes the frame.
// After the last zone, o_stall stays high while the frame is reduced:
// a mean division, a second pass over the stored zones, and a variance
// division, both divisions on the shared bit-serial divider.
// Output channel (o_valid / i_stall): one result per frame from an output
// register; the next frame loads while a result waits. If a result is still
// stalled when the next frame finishes, that frame waits before delivery.
// Reset is synchronous and clears the frame state and all handshakes; the
// frame store needs no clearing.
module depth_frame_variance_top #(
    parameter int MAX_ZONES = dfv_pkg::MAX_ZONES_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [dfv_pkg::DIST_W-1:0]  i_distance,
    input  logic                        i_last_zone,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [dfv_pkg::VAR_W-1:0]   o_variance,
    output logic [dfv_pkg::DIST_W-1:0]  o_mean,
    output logic [dfv_pkg::COUNT_W-1:0] o_valid_count,
    output logic                        o_no_valid
);

    dfv_pkg::t_dp_cmd  w_cmd;
    dfv_pkg::t_dp_stat w_stat;

    dfv_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_last_zone (i_last_zone),
        .i_stat      (w_stat),
        .o_stall     (o_stall),
        .o_cmd       (w_cmd)
    );

    dfv_dpath #(
        .MAX_ZONES (MAX_ZONES)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .i_distance    (i_distance),
        .o_stat        (w_stat),
        .i_out_stall   (i_stall),
        .o_out_valid   (o_valid),
        .o_variance    (o_variance),
        .o_mean        (o_mean),
        .o_valid_count (o_valid_count),
        .o_no_valid    (o_no_valid)
    );

endmodule

>>> sv/dfv_checker.sv
// port level checks of the depth frame variance block, bound to the top
module dfv_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_valid,
    input logic                        o_stall,
    input logic                        i_last_zone,
    input logic                        o_valid,
    input logic                        i_stall,
    input logic [dfv_pkg::VAR_W-1:0]   o_variance,
    input logic [dfv_pkg::DIST_W-1:0]  o_mean,
    input logic [dfv_pkg::COUNT_W-1:0] o_valid_count,
    input logic                        o_no_valid
);

    // no result straight after reset
    a_reset_clear: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    // a closing zone holds off input while the frame is reduced
    a_close_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && i_last_zone) |=> o_stall)
        else $error("input not stalled after last zone");

    // an empty frame reports zero statistics
    a_empty_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_no_valid) |->
        (o_variance == '0 && o_mean == '0 && o_valid_count == '0))
        else $error("empty frame with nonzero statistics");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=>
        (o_valid && $stable(o_variance) && $stable(o_mean) &&
         $stable(o_valid_count) && $stable(o_no_valid)))
        else $error("stalled result changed");

endmodule

bind depth_frame_variance_top dfv_checker u_dfv_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (i_valid),
    .o_stall       (o_stall),
    .i_last_zone   (i_last_zone),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_variance    (o_variance),
    .o_mean        (o_mean),
    .o_valid_count (o_valid_count),
    .o_no_valid    (o_no_valid)
);

>>> tb/depth_frame_variance_checker.sv
// result predictor and scoreboard for the depth frame variance block
`timescale 1ns / 100ps

module depth_frame_variance_checker #(
    parameter int MAX_ZONES = dfv_pkg::MAX_ZONES_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic                        i_in_stall,
    input  logic [dfv_pkg::DIST_W-1:0]  i_distance,
    input  logic                        i_last_zone,
    input  logic                        i_out_valid,
    input  logic                        i_out_stall,
    input  logic [dfv_pkg::VAR_W-1:0]   i_variance,
    input  logic [dfv_pkg::DIST_W-1:0]  i_mean,
    input  logic [dfv_pkg::COUNT_W-1:0] i_valid_count,
    input  logic                        i_no_valid,
    output int                          o_fail_count,
    output int                          o_pending
);

    typedef struct packed {
        logic [dfv_pkg::VAR_W-1:0]   variance;
        logic [dfv_pkg::DIST_W-1:0]  mean;
        logic [dfv_pkg::COUNT_W-1:0] valid_count;
        logic                        no_valid;
    } t_frame_result;

    // own copy of the frame state
    logic [dfv_pkg::DIST_W-1:0] zone_mem [MAX_ZONES];
    int unsigned                stored_zones;
    int unsigned                valid_zones;
    int unsigned                dist_sum;

    t_frame_result frame_results_q [$];
    int            mismatches;

    // mean, then squared deviations of the stored valid zones from it
    function automatic t_frame_result reduce_frame();
        t_frame_result     res;
        longint unsigned   sq_sum;
        longint unsigned   dev;
        int unsigned       avg;
        res    = '0;
        sq_sum = 0;
        if (valid_zones == 0) begin
            res.no_valid = 1'b1;
        end else begin
            avg = dist_sum / valid_zones;
            for (int k = 0; k < stored_zones; k++) begin
                if (zone_mem[k] != '0) begin
                    dev = (zone_mem[k] >= avg) ? longint'(zone_mem[k]) - avg
                                               : avg - longint'(zone_mem[k]);
                    sq_sum += dev * dev;
                end
            end
            res.variance    = dfv_pkg::VAR_W'(sq_sum / valid_zones);
            res.mean        = dfv_pkg::DIST_W'(avg);
            res.valid_count = dfv_pkg::COUNT_W'(valid_zones);
        end
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_frame_result want;
        if (!i_rst_n) begin
            stored_zones = 0;
            valid_zones  = 0;
            dist_sum     = 0;
            mismatches   = 0;
            frame_results_q.delete();
        end else begin
            // result transfer: compare with the oldest frame waiting
            if (i_out_valid && !i_out_stall) begin
                if (frame_results_q.size() == 0) begin
                    $error("result transfer with no frame pending");
                    mismatches++;
                end else begin
                    want = frame_results_q.pop_front();
                    if (i_variance !== want.variance) begin
                        $error("variance: expected %0d, actual %0d",
                               want.variance, i_variance);
                        mismatches++;
                    end
                    if (i_mean !== want.mean) begin
                        $error("mean: expected %0d, actual %0d", want.mean, i_mean);
                        mismatches++;
                    end
                    if (i_valid_count !== want.valid_count) begin
                        $error("valid_count: expected %0d, actual %0d",
                               want.valid_count, i_valid_count);
                        mismatches++;
                    end
                    if (i_no_valid !== want.no_valid) begin
                        $error("no_valid: expected %0d, actual %0d",
                               want.no_valid, i_no_valid);
                        mismatches++;
                    end
                end
            end
            // zone transfer: store while room is left, close on last flag
            if (i_in_valid && !i_in_stall) begin
                if (stored_zones < MAX_ZONES) begin
                    zone_mem[stored_zones] = i_distance;
                    stored_zones++;
                    if (i_distance != '0) begin
                        dist_sum += i_distance;
                        valid_zones++;
                    end
                end
                if (i_last_zone) begin
                    frame_results_q.push_back(reduce_frame());
                    stored_zones = 0;
                    valid_zones  = 0;
                    dist_sum     = 0;
                end
            end
        end
        o_fail_count <= mismatches;
        o_pending    <= frame_results_q.size();
    end

endmodule

>>> tb/depth_frame_variance_top_test.sv
// stimulus, clocking and verdict for the depth frame variance block
`timescale 1ns / 100ps

module depth_frame_variance_top_test;

    localparam int CLK_PERIOD   = 8;
    localparam int MAX_ZONES    = dfv_pkg::MAX_ZONES_DEF;
    localparam int TARGET_ZONES = 520;
    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 200;

    logic                        i_clk        = 1'b0;
    logic                        i_rst_n      = 1'b0;
    logic                        i_valid      = 1'b0;
    logic                        o_stall;
    logic [dfv_pkg::DIST_W-1:0]  i_distance   = '0;
    logic                        i_last_zone  = 1'b0;
    logic                        o_valid;
    logic                        i_stall      = 1'b0;
    logic [dfv_pkg::VAR_W-1:0]   o_variance;
    logic [dfv_pkg::DIST_W-1:0]  o_mean;
    logic [dfv_pkg::COUNT_W-1:0] o_valid_count;
    logic                        o_no_valid;

    int fail_count;
    int pending_frames;
    int zones_sent   = 0;
    int burst_left   = 0;
    int stall_left   = 0;
    int idle_cycles  = 0;

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    depth_frame_variance_top #(.MAX_ZONES(MAX_ZONES)) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_distance    (i_distance),
        .i_last_zone   (i_last_zone),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_variance    (o_variance),
        .o_mean        (o_mean),
        .o_valid_count (o_valid_count),
        .o_no_valid    (o_no_valid)
    );

    depth_frame_variance_checker #(.MAX_ZONES(MAX_ZONES)) frame_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_valid),
        .i_in_stall    (o_stall),
        .i_distance    (i_distance),
        .i_last_zone   (i_last_zone),
        .i_out_valid   (o_valid),
        .i_out_stall   (i_stall),
        .i_variance    (o_variance),
        .i_mean        (o_mean),
        .i_valid_count (o_valid_count),
        .i_no_valid    (o_no_valid),
        .o_fail_count  (fail_count),
        .o_pending     (pending_frames)
    );

    // receiver: alternating free and stalled stretches of random length
    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            if (i_stall) begin
                i_stall    <= 1'b0;
                stall_left <= $urandom_range(1, 50);
            end else begin
                i_stall    <= 1'b1;
                stall_left <= $urandom_range(1, 20);
            end
        end else begin
            stall_left <= stall_left - 1;
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // one zone transfer, then a random gap, possibly none, once the current burst runs out
    task automatic send_zone(input logic [dfv_pkg::DIST_W-1:0] zone_dist, input logic last);
        int gap;
        i_valid     <= 1'b1;
        i_distance  <= zone_dist;
        i_last_zone <= last;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        zones_sent++;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 30);
        end
    endtask

    // hold the sender until every closed frame has delivered its result
    task automatic wait_frames_done();
        do @(posedge i_clk); while (pending_frames != 0);
    endtask

    initial begin
        int  frame_len;
        int  frame_kind;
        int  base;
        int  d;
        bit  held_once;
        held_once = 1'b0;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        burst_left = $urandom_range(1, 30);

        // single zone at full range, then a single invalid zone
        send_zone(13'd8191, 1'b1);
        send_zone(13'd0, 1'b1);
        // extremes together give the widest spread
        send_zone(13'd1, 1'b0);
        send_zone(13'd8191, 1'b1);
        // frame with no valid zone
        send_zone(13'd0, 1'b0);
        send_zone(13'd0, 1'b0);
        send_zone(13'd0, 1'b1);
        // invalid zones mixed in, closing on a valid one
        send_zone(13'd0, 1'b0);
        send_zone(13'd100, 1'b0);
        send_zone(13'd0, 1'b0);
        send_zone(13'd103, 1'b0);
        send_zone(13'd7, 1'b1);
        // identical readings: zero variance
        send_zone(13'd5000, 1'b0);
        send_zone(13'd5000, 1'b0);
        send_zone(13'd5000, 1'b1);
        // large and small values mixed, with a mean that divides exactly
        send_zone(13'd8191, 1'b0);
        send_zone(13'd8191, 1'b0);
        send_zone(13'd1, 1'b0);
        send_zone(13'd1, 1'b0);
        send_zone(13'd4096, 1'b1);
        i_valid <= 1'b0;
        wait_frames_done();

        // random frames: mostly short, some full, one short of full or overfull
        while (zones_sent < TARGET_ZONES) begin
            case ($urandom_range(0, 19))
                0:       frame_len = MAX_ZONES;
                1:       frame_len = $urandom_range(MAX_ZONES + 1, MAX_ZONES + 16);
                2:       frame_len = MAX_ZONES - 1;
                default: frame_len = $urandom_range(1, 12);
            endcase
            frame_kind = $urandom_range(0, 9);
            base       = $urandom_range(4, 8187);
            for (int z = 0; z < frame_len; z++) begin
                if (frame_kind == 0) begin
                    d = 0;
                end else if (frame_kind == 1) begin
                    d = $urandom_range(base - 3, base + 3);
                end else if ($urandom_range(0, 4) == 0) begin
                    d = 0;
                end else begin
                    d = $urandom_range(1, 8191);
                end
                send_zone(dfv_pkg::DIST_W'(d), z == frame_len - 1);
            end
            // one drain in the middle of the random part
            if (!held_once && zones_sent >= TARGET_ZONES / 2) begin
                held_once = 1'b1;
                i_valid <= 1'b0;
                wait_frames_done();
            end
        end
        i_valid <= 1'b0;

        wait_frames_done();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending_frames == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
